// ----- hw/rtl/bhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary heap priority queue package
// Operation and error codes, and the request control word that passes from
// the front end to the heap engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

  // Operation carried by one request.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // Error code returned with every result.
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  // Control word of a queued request.
  typedef struct packed {
    logic valid;
    op_e  op;
  } req_ctrl_t;

  // Heap order after reset: largest key at the top.
  localparam logic ORDER_MAX_RESET = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/bhpq_front.sv -----
// ----------------------------------------------------------------------------
// Binary heap priority queue front end
// Accepts requests, decodes the operation and holds them in a two-entry
// queue so that the input side keeps moving while the heap engine works.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_front #(
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  mode_i,
  input  wire logic [KEY_WIDTH-1:0]  key_i,
  output bhpq_pkg::req_ctrl_t        req_o,
  output logic      [KEY_WIDTH-1:0]  req_key_o,
  input  wire logic                  req_ready_i
);

  logic [1:0]          fill_q, fill_d;
  logic                wr_ptr_q, rd_ptr_q;
  bhpq_pkg::op_e       op_mem_q [2];
  logic [KEY_WIDTH-1:0] key_mem_q [2];
  bhpq_pkg::op_e       op_dec;
  logic                push, pop;

  // Decode the request mode into an operation.
  assign op_dec = mode_i ? bhpq_pkg::OP_POP : bhpq_pkg::OP_PUSH;

  // Queue handshakes.
  assign in_ready_o = (fill_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = req_o.valid && req_ready_i;

  // Head of the queue towards the engine.
  assign req_o.valid = (fill_q != 2'd0);
  assign req_o.op    = op_mem_q[rd_ptr_q];
  assign req_key_o   = key_mem_q[rd_ptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Queue payload storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      op_mem_q[wr_ptr_q]  <= op_dec;
      key_mem_q[wr_ptr_q] <= key_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bhpq_back.sv -----
// ----------------------------------------------------------------------------
// Binary heap priority queue engine
// Holds the heap store and the entry count, carries out one push (sift up)
// or pop (sift down) at a time and registers the result for the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_back #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_wdata_i,
  input  wire bhpq_pkg::req_ctrl_t         req_i,
  input  wire logic [KEY_WIDTH-1:0]        req_key_i,
  output logic                             req_ready_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             top_valid_o,
  output logic [KEY_WIDTH-1:0]             top_key_o,
  output logic [$clog2(DEPTH+1)-1:0]       entry_count_o,
  output bhpq_pkg::err_e                   error_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_UP_PUT,
    S_DN_LAST,
    S_DN_RD,
    S_DN_CMP
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [KEY_WIDTH-1:0] mov_q, mov_d;
  logic [KEY_WIDTH-1:0] top_q, top_d;
  logic                 rv_q, rv_d;
  logic                 order_q, order_d;
  logic                 out_valid_q, out_valid_d;
  logic                 top_valid_q, top_valid_d;
  logic [KEY_WIDTH-1:0] top_key_q, top_key_d;
  logic [CW-1:0]        out_count_q, out_count_d;
  bhpq_pkg::err_e       err_q, err_d;

  // Heap store, one write and two registered read ports.
  logic [KEY_WIDTH-1:0] mem_q [DEPTH];
  logic [KEY_WIDTH-1:0] rd0_q, rd1_q;
  logic [AW-1:0]        rd0_addr, rd1_addr, wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic                 wr_en;

  // Index arithmetic of the tree.
  logic [AW-1:0]        parent_idx;
  logic [IW-1:0]        left_w, right_w;
  logic [CW-1:0]        last_idx;
  logic                 left_in, right_in;
  logic                 finish;
  bhpq_pkg::err_e       fin_err;
  logic                 take_l, take_r;
  logic [KEY_WIDTH-1:0] best_key;

  // True when key a must sit below key b under the selected order.
  function automatic logic below(input logic [KEY_WIDTH-1:0] a,
                                 input logic [KEY_WIDTH-1:0] b,
                                 input logic                 omax);
    below = omax ? (a < b) : (a > b);
  endfunction

  assign parent_idx = (pos_q - AW'(1)) >> 1;
  assign left_w     = {pos_q, 1'b1};
  assign right_w    = {pos_q, 1'b0} + IW'(2);
  assign last_idx   = count_q - CW'(1);
  assign left_in    = (left_w < IW'(count_q));
  assign right_in   = (right_w < IW'(count_q));

  // Child selection during sift down; the left child wins a tie.
  assign take_l   = below(mov_q, rd0_q, order_q);
  assign best_key = take_l ? rd0_q : mov_q;
  assign take_r   = rv_q && below(best_key, rd1_q, order_q);

  assign req_ready_o = (state_q == S_IDLE) && !out_valid_q;

  // Sequencer of the sift operations.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    mov_d       = mov_q;
    rv_d        = rv_q;
    order_d     = order_q;
    out_valid_d = out_valid_q;
    top_valid_d = top_valid_q;
    top_key_d   = top_key_q;
    out_count_d = out_count_q;
    err_d       = err_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = mov_q;
    rd0_addr    = parent_idx;
    rd1_addr    = pos_q;
    finish      = 1'b0;
    fin_err     = bhpq_pkg::ERR_NONE;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_we_i) begin
      order_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        rd0_addr = last_idx[AW-1:0];
        if (req_i.valid && !out_valid_q) begin
          if (req_i.op == bhpq_pkg::OP_PUSH) begin
            if (count_q == CW'(DEPTH)) begin
              finish  = 1'b1;
              fin_err = bhpq_pkg::ERR_FULL;
            end else begin
              mov_d   = req_key_i;
              pos_d   = count_q[AW-1:0];
              count_d = count_q + CW'(1);
              if (count_q == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = req_key_i;
                finish  = 1'b1;
              end else begin
                state_d = S_UP_RD;
              end
            end
          end else begin
            if (count_q == '0) begin
              finish  = 1'b1;
              fin_err = bhpq_pkg::ERR_EMPTY;
            end else begin
              count_d = last_idx;
              if (count_q == CW'(1)) begin
                finish = 1'b1;
              end else begin
                state_d = S_DN_LAST;
              end
            end
          end
        end
      end
      S_UP_RD: begin
        rd0_addr = parent_idx;
        state_d  = S_UP_CMP;
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (below(rd0_q, mov_q, order_q)) begin
          // Parent moves down one level; the new key climbs.
          wr_data = rd0_q;
          pos_d   = parent_idx;
          state_d = (parent_idx == '0) ? S_UP_PUT : S_UP_RD;
        end else begin
          finish = 1'b1;
        end
      end
      S_UP_PUT: begin
        wr_en  = 1'b1;
        finish = 1'b1;
      end
      S_DN_LAST: begin
        mov_d   = rd0_q;
        pos_d   = '0;
        state_d = S_DN_RD;
      end
      S_DN_RD: begin
        rd0_addr = left_w[AW-1:0];
        rd1_addr = right_w[AW-1:0];
        if (!left_in) begin
          wr_en  = 1'b1;
          finish = 1'b1;
        end else begin
          rv_d    = right_in;
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data = rd1_q;
          pos_d   = right_w[AW-1:0];
          state_d = S_DN_RD;
        end else if (take_l) begin
          wr_data = rd0_q;
          pos_d   = left_w[AW-1:0];
          state_d = S_DN_RD;
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The root is tracked alongside the store.
    top_d = (wr_en && (wr_addr == '0)) ? wr_data : top_q;

    // Load the result register when the operation completes.
    if (finish) begin
      state_d     = S_IDLE;
      out_valid_d = 1'b1;
      top_valid_d = (count_d != '0);
      top_key_d   = (count_d != '0) ? top_d : '0;
      out_count_d = count_d;
      err_d       = fin_err;
    end
  end

  // State, count, order register and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      order_q     <= bhpq_pkg::ORDER_MAX_RESET;
      out_valid_q <= 1'b0;
      top_valid_q <= 1'b0;
      top_key_q   <= '0;
      out_count_q <= '0;
      err_q       <= bhpq_pkg::ERR_NONE;
      pos_q       <= '0;
      mov_q       <= '0;
      top_q       <= '0;
      rv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      order_q     <= order_d;
      out_valid_q <= out_valid_d;
      top_valid_q <= top_valid_d;
      top_key_q   <= top_key_d;
      out_count_q <= out_count_d;
      err_q       <= err_d;
      pos_q       <= pos_d;
      mov_q       <= mov_d;
      top_q       <= top_d;
      rv_q        <= rv_d;
    end
  end

  // Heap store access.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd0_q <= mem_q[rd0_addr];
    rd1_q <= mem_q[rd1_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign top_valid_o   = top_valid_q;
  assign top_key_o     = top_key_q;
  assign entry_count_o = out_count_q;
  assign error_o       = err_q;

endmodule

`default_nettype wire

// ----- hw/rtl/binary_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Push and pop requests on a heap held in a single store, with min or max
// order selected by a configuration register.
// ----------------------------------------------------------------------------
// Sequence: a refused request, a push into an empty heap or a pop of the last
//   entry completes when it is accepted; otherwise a start step is followed, per
//   tree level walked, by one store read and then one compare and write.
// Requests run one at a time; the next can start the cycle after the result
//   is taken. Reset empties the heap and selects max order.
`default_nettype none

module binary_heap_priority_queue #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        mode_i,
  input  wire logic [KEY_WIDTH-1:0]        key_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             top_valid_o,
  output logic [KEY_WIDTH-1:0]             top_key_o,
  output logic [$clog2(DEPTH+1)-1:0]       entry_count_o,
  output logic [1:0]                       error_o
);

  localparam int CW = $clog2(DEPTH + 1);

  bhpq_pkg::req_ctrl_t  req;
  logic [KEY_WIDTH-1:0] req_key;
  logic                 req_ready;
  bhpq_pkg::err_e       err;

  // Request decode and queue.
  bhpq_front #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .key_i       (key_i),
    .req_o       (req),
    .req_key_o   (req_key),
    .req_ready_i (req_ready)
  );

  // Heap engine and result register.
  bhpq_back #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_i         (req),
    .req_key_i     (req_key),
    .req_ready_o   (req_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .top_valid_o   (top_valid_o),
    .top_key_o     (top_key_o),
    .entry_count_o (entry_count_o),
    .error_o       (err)
  );

  assign error_o = err;

  // A refused push reports a full heap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_o == bhpq_pkg::ERR_FULL) |-> entry_count_o == CW'(DEPTH))
    else $error("push refused while heap not full");

  // A refused pop reports an empty heap with a zero key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_o == bhpq_pkg::ERR_EMPTY)
      |-> !top_valid_o && (entry_count_o == '0) && (top_key_o == '0))
    else $error("pop refused while heap not empty");

  // The top flag follows the entry count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (top_valid_o == (entry_count_o != '0)))
    else $error("top flag disagrees with entry count");

  // The count never exceeds the store size and the error code is defined.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (entry_count_o <= CW'(DEPTH)) && (error_o != 2'd3))
    else $error("result out of range");

endmodule

`default_nettype wire

// ----- bench/bhpq_checker.sv -----
// ----------------------------------------------------------------------------
// Binary heap priority queue checker
// Watches the configuration port and the request and result channels of the heap,
// keeps its own heap image to work out the result of every accepted request,
// and compares each delivered result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_checker #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  parameter int COUNT_W   = $clog2(DEPTH+1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_wdata_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire logic                 mode_i,
  input  wire logic [KEY_WIDTH-1:0] key_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire logic                 top_valid_i,
  input  wire logic [KEY_WIDTH-1:0] top_key_i,
  input  wire logic [COUNT_W-1:0]   entry_count_i,
  input  wire logic [1:0]           error_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  // One result as the heap should report it.
  typedef struct packed {
    logic                 top_valid;
    logic [KEY_WIDTH-1:0] top_key;
    logic [COUNT_W-1:0]   entry_count;
    bhpq_pkg::err_e       error;
  } heap_result_t;

  heap_result_t         results_due[$];
  logic [KEY_WIDTH-1:0] heap_image[DEPTH];
  int unsigned          image_fill;
  logic                 image_order_max;
  int                   mismatches;

  // True when key a has to sit beneath key b in the current order.
  function automatic logic sits_below(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
    return image_order_max ? (a < b) : (a > b);
  endfunction

  function automatic void swap_entries(int unsigned i, int unsigned j);
    logic [KEY_WIDTH-1:0] held;
    held          = heap_image[i];
    heap_image[i] = heap_image[j];
    heap_image[j] = held;
  endfunction

  // Apply one push or pop to the heap image and work out its result.
  function automatic heap_result_t run_heap_request(logic op, logic [KEY_WIDTH-1:0] key);
    heap_result_t res;
    int unsigned  pos;
    int unsigned  parent;
    int unsigned  left;
    int unsigned  right;
    int unsigned  best;
    logic         settled;
    res.error = bhpq_pkg::ERR_NONE;
    if (op == bhpq_pkg::OP_PUSH) begin
      if (image_fill >= DEPTH) begin
        res.error = bhpq_pkg::ERR_FULL;
      end else begin
        heap_image[image_fill] = key;
        pos        = image_fill;
        image_fill = image_fill + 1;
        settled    = 1'b0;
        // Sift up while the parent is strictly worse.
        while (pos > 0 && !settled) begin
          parent = (pos - 1) / 2;
          if (sits_below(heap_image[parent], heap_image[pos])) begin
            swap_entries(parent, pos);
            pos = parent;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end else begin
      if (image_fill == 0) begin
        res.error = bhpq_pkg::ERR_EMPTY;
      end else begin
        image_fill    = image_fill - 1;
        heap_image[0] = heap_image[image_fill];
        pos           = 0;
        settled       = 1'b0;
        // Sift down towards the better child; the left one wins a tie.
        while (!settled) begin
          left  = pos * 2 + 1;
          right = pos * 2 + 2;
          best  = pos;
          if (left < image_fill && sits_below(heap_image[best], heap_image[left])) begin
            best = left;
          end
          if (right < image_fill && sits_below(heap_image[best], heap_image[right])) begin
            best = right;
          end
          if (best == pos) begin
            settled = 1'b1;
          end else begin
            swap_entries(pos, best);
            pos = best;
          end
        end
      end
    end
    res.top_valid   = (image_fill > 0);
    res.top_key     = (image_fill > 0) ? heap_image[0] : '0;
    res.entry_count = image_fill[COUNT_W-1:0];
    return res;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches = mismatches + 1;
    end
  endfunction

  // Compare delivered results first, then take in configuration and requests.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    heap_result_t want;
    if (!rst_ni) begin
      results_due.delete();
      image_fill      = 0;
      image_order_max = bhpq_pkg::ORDER_MAX_RESET;
      mismatches      = 0;
      fail_count_o    <= 0;
      pending_o       <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, actual %0h",
                   $time, top_key_i);
          mismatches = mismatches + 1;
        end else begin
          want = results_due.pop_front();
          check_field("top_valid", 64'(want.top_valid), 64'(top_valid_i));
          check_field("top_key", 64'(want.top_key), 64'(top_key_i));
          check_field("entry_count", 64'(want.entry_count), 64'(entry_count_i));
          check_field("error", 64'(want.error), 64'(error_i));
        end
      end
      if (cfg_we_i) begin
        image_order_max = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        results_due.push_back(run_heap_request(mode_i, key_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= results_due.size();
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_binary_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Binary heap priority queue testbench
// Drives directed and random push and pop requests in bursts, stalls the
// result side on changing patterns, switches the heap order while idle and
// leaves all checking to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_binary_heap_priority_queue;

  localparam int DEPTH          = 64;
  localparam int KEY_WIDTH      = 32;
  localparam int COUNT_W        = $clog2(DEPTH+1);
  localparam int RANDOM_ITEMS   = 1450;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic                 cfg_wdata_i = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 mode_i      = 1'b0;
  logic [KEY_WIDTH-1:0] key_i       = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 top_valid_o;
  logic [KEY_WIDTH-1:0] top_key_o;
  logic [COUNT_W-1:0]   entry_count_o;
  logic [1:0]           error_o;

  int   fail_count;
  int   pending;
  int   burst_left   = 10;
  int   stall_cycles = 0;
  logic long_hold_go = 1'b0;
  logic hold_done    = 1'b0;

  binary_heap_priority_queue #(
    .DEPTH    (DEPTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .top_valid_o  (top_valid_o),
    .top_key_o    (top_key_o),
    .entry_count_o(entry_count_o),
    .error_o      (error_o)
  );

  bhpq_checker #(
    .DEPTH    (DEPTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .top_valid_i  (top_valid_o),
    .top_key_i    (top_key_o),
    .entry_count_i(entry_count_o),
    .error_i      (error_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offer one request and hold it until accepted; gaps fall between bursts.
  task automatic send_request(input bhpq_pkg::op_e op, input logic [KEY_WIDTH-1:0] key);
    mode_i     <= op;
    key_i      <= key;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
    end
  endtask

  // Stop offering and wait until every outstanding result has been delivered.
  // One edge first, so that a request taken at the last edge is counted.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_order(input logic order_max);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= order_max;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Keys drawn from the full range, tight ranges at the bottom and top for ties, or the extremes.
  function automatic logic [KEY_WIDTH-1:0] pick_key();
    logic [KEY_WIDTH-1:0] key;
    case ($urandom_range(0, 3))
      0: key = $urandom();
      1: key = $urandom_range(0, 7);
      2: begin
        case ($urandom_range(0, 3))
          0:       key = '0;
          1:       key = '1;
          2:       key = 32'h0000_0001;
          default: key = 32'hFFFF_FFFE;
        endcase
      end
      default: key = 32'hFFFF_FFF8 | $urandom_range(0, 7);
    endcase
    return key;
  endfunction

  // Result side: changing stall patterns, plus one long hold-off on request.
  initial begin : receiver
    int ready_style;
    int ready_phase;
    ready_style = 0;
    ready_phase = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold_go && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (ready_phase % 50 == 0) begin
          ready_style = $urandom_range(0, 4);
        end
        case (ready_style)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          3:       out_ready_i <= (ready_phase % 7 < 4);
          default: out_ready_i <= ($urandom_range(0, 9) != 0);
        endcase
        ready_phase = ready_phase + 1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: ends the run when no request moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int            random_sent;
    int            segment;
    int            seg_len;
    int            push_pct;
    bhpq_pkg::op_e op;
    random_sent = 0;
    segment     = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part in max order: pop from empty, extreme and equal keys.
    send_request(bhpq_pkg::OP_POP, $urandom());
    send_request(bhpq_pkg::OP_PUSH, 32'h0000_0000);
    send_request(bhpq_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_request(bhpq_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_request(bhpq_pkg::OP_PUSH, 32'h0000_0001);
    send_request(bhpq_pkg::OP_PUSH, 32'h8000_0000);
    send_request(bhpq_pkg::OP_PUSH, 32'h7FFF_FFFF);
    repeat (7) send_request(bhpq_pkg::OP_POP, $urandom());

    // Min order, with ties and extremes.
    set_order(1'b0);
    send_request(bhpq_pkg::OP_PUSH, 32'h0000_0005);
    send_request(bhpq_pkg::OP_PUSH, 32'h0000_0005);
    send_request(bhpq_pkg::OP_PUSH, 32'h0000_0000);
    send_request(bhpq_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_request(bhpq_pkg::OP_PUSH, 32'h0000_0003);
    repeat (2) send_request(bhpq_pkg::OP_POP, $urandom());

    // Order switched back while entries are still held.
    set_order(1'b1);
    send_request(bhpq_pkg::OP_PUSH, 32'h0000_0002);
    send_request(bhpq_pkg::OP_POP, $urandom());

    // Random segments with a push or pop bias so that the heap fills and drains.
    while (random_sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(30, 120);
      case ($urandom_range(0, 3))
        0:       push_pct = 90;
        1:       push_pct = 50;
        2:       push_pct = 15;
        default: push_pct = 70;
      endcase
      // One push-heavy segment runs against a long hold-off of the result side.
      if (segment == 1) begin
        push_pct     = 90;
        seg_len      = 150;
        long_hold_go <= 1'b1;
      end
      repeat (seg_len) begin
        op = ($urandom_range(0, 99) < push_pct) ? bhpq_pkg::OP_PUSH : bhpq_pkg::OP_POP;
        send_request(op, pick_key());
        random_sent = random_sent + 1;
      end
      if ($urandom_range(0, 2) == 0) begin
        set_order(1'($urandom_range(0, 1)));
      end
      segment = segment + 1;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/bhpq_pkg.sv
hw/rtl/bhpq_front.sv
hw/rtl/bhpq_back.sv
hw/rtl/binary_heap_priority_queue.sv
bench/bhpq_checker.sv
bench/tb_binary_heap_priority_queue.sv
